// File: rtl/bdcd_pkg.sv
// Shared types and constants for the button debounce and click detector.
// Holds the register map, the configuration struct and the result struct.
// Used by bdcd_cfg_regs, bdcd_engine and button_debounce_click_detector_unit.
package bdcd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ClickW = 2;

  // Reset values of the configuration registers
  localparam logic [MsW-1:0] DebounceMsRst    = MsW'(50);
  localparam logic [MsW-1:0] LongPressMsRst   = MsW'(1000);
  localparam logic [MsW-1:0] DoubleClickMsRst = MsW'(300);

  // Click count values
  localparam logic [ClickW-1:0] ClickNone   = ClickW'(0);
  localparam logic [ClickW-1:0] ClickSingle = ClickW'(1);
  localparam logic [ClickW-1:0] ClickPair   = ClickW'(2);

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCK_ENABLE      = 3'd0,
    REG_ACTIVE_LOW        = 3'd1,
    REG_LONG_PRESS_ENABLE = 3'd2,
    REG_DEBOUNCE_MS       = 3'd3,
    REG_LONG_PRESS_MS     = 3'd4,
    REG_DOUBLE_CLICK_MS   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic           block_enable;
    logic           active_low;
    logic           long_press_enable;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
    logic [MsW-1:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic             press_event;
    logic             release_event;
    logic             long_press_event;
    logic             click_event;
    logic             double_click_event;
    logic             is_pressed;
    logic [TimeW-1:0] held_ms;
  } res_t;

endpackage

// File: rtl/bdcd_cfg_regs.sv
// Configuration register file of the button debounce and click detector.
// Depends on bdcd_pkg for the register map and the cfg_t struct.
module bdcd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bdcd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bdcd_pkg::MsW-1:0]        cfg_wdata,
  output bdcd_pkg::cfg_t                  cfg
);

  bdcd_pkg::cfg_t cfg_r;

  // Decode the write and keep only the low bits of each register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_enable      <= 1'b1;
      cfg_r.active_low        <= 1'b1;
      cfg_r.long_press_enable <= 1'b1;
      cfg_r.debounce_ms       <= bdcd_pkg::DebounceMsRst;
      cfg_r.long_press_ms     <= bdcd_pkg::LongPressMsRst;
      cfg_r.double_click_ms   <= bdcd_pkg::DoubleClickMsRst;
    end else if (cfg_we) begin
      case (cfg_index)
        bdcd_pkg::REG_BLOCK_ENABLE:      cfg_r.block_enable      <= cfg_wdata[0];
        bdcd_pkg::REG_ACTIVE_LOW:        cfg_r.active_low        <= cfg_wdata[0];
        bdcd_pkg::REG_LONG_PRESS_ENABLE: cfg_r.long_press_enable <= cfg_wdata[0];
        bdcd_pkg::REG_DEBOUNCE_MS:       cfg_r.debounce_ms       <= cfg_wdata;
        bdcd_pkg::REG_LONG_PRESS_MS:     cfg_r.long_press_ms     <= cfg_wdata;
        bdcd_pkg::REG_DOUBLE_CLICK_MS:   cfg_r.double_click_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/bdcd_engine.sv
// Debounce, press/release, long-press and click state with its one-pass update.
// Depends on bdcd_pkg for cfg_t, res_t and the click count constants.
module bdcd_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          level,
  input  logic [bdcd_pkg::TimeW-1:0]    now_ms,
  input  bdcd_pkg::cfg_t                cfg,
  output bdcd_pkg::res_t                res
);

  localparam int unsigned TW = bdcd_pkg::TimeW;

  logic                         prev_level_r,  prev_level_nxt;
  logic [TW-1:0]                change_time_r, change_time_nxt;
  logic                         pressed_r,     pressed_nxt;
  logic [TW-1:0]                press_start_r, press_start_nxt;
  logic                         long_fired_r,  long_fired_nxt;
  logic [bdcd_pkg::ClickW-1:0]  click_cnt_r,   click_cnt_nxt;
  logic [TW-1:0]                click_time_r,  click_time_nxt;

  logic                         stable;
  logic                         want;
  logic                         ev_press, ev_release, ev_long, ev_click, ev_double;
  logic                         lf_mid;
  logic [bdcd_pkg::ClickW-1:0]  cc_inc, cc_mid;
  logic [TW-1:0]                ct_mid, hold_time;

  // Compute next state and events for the transaction in the input register
  always_comb begin
    ev_press = 1'b0;
    ev_release = 1'b0;
    ev_long = 1'b0;
    ev_click = 1'b0;
    ev_double = 1'b0;

    // Track the last raw change
    change_time_nxt = (level != prev_level_r) ? now_ms : change_time_r;
    stable = (now_ms - change_time_nxt) > {{(TW-bdcd_pkg::MsW){1'b0}}, cfg.debounce_ms};
    want = cfg.active_low ? ~level : level;

    // Press and release edges
    pressed_nxt = pressed_r;
    press_start_nxt = press_start_r;
    lf_mid = long_fired_r;
    cc_mid = click_cnt_r;
    ct_mid = click_time_r;
    cc_inc = click_cnt_r + bdcd_pkg::ClickW'(1);
    if (stable && want && !pressed_r) begin
      pressed_nxt = 1'b1;
      press_start_nxt = now_ms;
      lf_mid = 1'b0;
      ev_press = 1'b1;
    end else if (stable && !want && pressed_r) begin
      pressed_nxt = 1'b0;
      ev_release = 1'b1;
      if (!long_fired_r) begin
        ct_mid = now_ms;
        if (cc_inc == bdcd_pkg::ClickPair) begin
          ev_double = 1'b1;
          cc_mid = bdcd_pkg::ClickNone;
        end else begin
          cc_mid = cc_inc;
        end
      end
    end

    // Long press fires once per hold
    hold_time = now_ms - press_start_nxt;
    long_fired_nxt = lf_mid;
    if (stable && pressed_nxt && !lf_mid && cfg.long_press_enable &&
        hold_time >= {{(TW-bdcd_pkg::MsW){1'b0}}, cfg.long_press_ms}) begin
      long_fired_nxt = 1'b1;
      ev_long = 1'b1;
    end

    // Close the click window
    click_cnt_nxt = cc_mid;
    click_time_nxt = ct_mid;
    if (cc_mid != bdcd_pkg::ClickNone &&
        (now_ms - ct_mid) > {{(TW-bdcd_pkg::MsW){1'b0}}, cfg.double_click_ms}) begin
      ev_click = (cc_mid == bdcd_pkg::ClickSingle);
      click_cnt_nxt = bdcd_pkg::ClickNone;
    end

    prev_level_nxt = level;

    // Drive the result; a disabled block reports frozen state only
    if (cfg.block_enable) begin
      res.press_event        = ev_press;
      res.release_event      = ev_release;
      res.long_press_event   = ev_long;
      res.click_event        = ev_click;
      res.double_click_event = ev_double;
      res.is_pressed         = pressed_nxt;
      res.held_ms            = pressed_nxt ? hold_time : '0;
    end else begin
      res.press_event        = 1'b0;
      res.release_event      = 1'b0;
      res.long_press_event   = 1'b0;
      res.click_event        = 1'b0;
      res.double_click_event = 1'b0;
      res.is_pressed         = pressed_r;
      res.held_ms            = pressed_r ? (now_ms - press_start_r) : '0;
    end
  end

  // Commit state when an enabled transaction leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      change_time_r <= '0;
      pressed_r     <= 1'b0;
      press_start_r <= '0;
      long_fired_r  <= 1'b0;
      click_cnt_r   <= bdcd_pkg::ClickNone;
      click_time_r  <= '0;
    end else if (step_en && cfg.block_enable) begin
      prev_level_r  <= prev_level_nxt;
      change_time_r <= change_time_nxt;
      pressed_r     <= pressed_nxt;
      press_start_r <= press_start_nxt;
      long_fired_r  <= long_fired_nxt;
      click_cnt_r   <= click_cnt_nxt;
      click_time_r  <= click_time_nxt;
    end
  end

endmodule

// File: rtl/button_debounce_click_detector_unit.sv
// Top level of the button debounce and click detector.
// Depends on bdcd_pkg, bdcd_cfg_regs and bdcd_engine.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | in_raw_level, in_now_ms
//   out     | out_valid / out_ready| out_press_event .. out_held_ms
//   cfg     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One poll per clock while the output is not stalled: a transaction is held in
// the input register, the state update and result are computed from it in one
// pass, and the result is then registered in the output register.
// Reset (synchronous, rst_n low) empties both registers and restores all state.
// A stalled output holds its result; the input register still takes one more
// transaction, then in_ready drops until out_ready frees the output.
module button_debounce_click_detector_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_raw_level,
  input  logic [bdcd_pkg::TimeW-1:0]       in_now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_press_event,
  output logic                             out_release_event,
  output logic                             out_long_press_event,
  output logic                             out_click_event,
  output logic                             out_double_click_event,
  output logic                             out_is_pressed,
  output logic [bdcd_pkg::TimeW-1:0]       out_held_ms,
  input  logic                             cfg_we,
  input  logic [bdcd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bdcd_pkg::MsW-1:0]         cfg_wdata
);

  bdcd_pkg::cfg_t cfg;
  bdcd_pkg::res_t res;
  bdcd_pkg::res_t out_r;

  logic                         s1_valid_r;
  logic                         s1_level_r;
  logic [bdcd_pkg::TimeW-1:0]   s1_now_r;
  logic                         out_valid_r;
  logic                         out_free;
  logic                         step_en;

  assign out_free = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  bdcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdcd_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .level   (s1_level_r),
    .now_ms  (s1_now_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register: take a transaction when the stage is empty or advancing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level_r <= in_raw_level;
      s1_now_r   <= in_now_ms;
    end
  end

  // Output register: load the result, hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_press_event        = out_r.press_event;
  assign out_release_event      = out_r.release_event;
  assign out_long_press_event   = out_r.long_press_event;
  assign out_click_event        = out_r.click_event;
  assign out_double_click_event = out_r.double_click_event;
  assign out_is_pressed         = out_r.is_pressed;
  assign out_held_ms            = out_r.held_ms;

  // Press and release edges never share one poll
  a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_press_event && out_release_event))
    else $error("press and release in one result");

  // A double click is always a release, never with a single click
  a_double_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_double_click_event) |-> (out_release_event && !out_click_event))
    else $error("double click without release");

  // A released button reports no hold time
  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_pressed) |-> (out_held_ms == '0))
    else $error("hold time while released");

  // A stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_r)))
    else $error("stalled result changed");

endmodule

// File: test/bdcd_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the button debounce and click detector testbench.
// Tracks debounce, hold and click state per poll; depends on bdcd_pkg.
package bdcd_tb_pkg;

  class button_event_scoreboard;
    // Shadow copy of the configuration registers
    logic                    block_enable;
    logic                    active_low;
    logic                    long_press_enable;
    logic [bdcd_pkg::MsW-1:0] debounce_ms;
    logic [bdcd_pkg::MsW-1:0] long_press_ms;
    logic [bdcd_pkg::MsW-1:0] double_click_ms;

    // Debounce and click tracking state
    logic                        prev_level;
    logic [bdcd_pkg::TimeW-1:0]  change_time;
    logic                        pressed;
    logic [bdcd_pkg::TimeW-1:0]  press_start;
    logic                        long_fired;
    logic [bdcd_pkg::ClickW-1:0] clicks;
    logic [bdcd_pkg::TimeW-1:0]  click_time;

    bdcd_pkg::res_t expected_events[$];
    int unsigned    errors;

    function new();
      block_enable      = 1'b1;
      active_low        = 1'b1;
      long_press_enable = 1'b1;
      debounce_ms       = bdcd_pkg::DebounceMsRst;
      long_press_ms     = bdcd_pkg::LongPressMsRst;
      double_click_ms   = bdcd_pkg::DoubleClickMsRst;
      prev_level        = 1'b1;
      change_time       = '0;
      pressed           = 1'b0;
      press_start       = '0;
      long_fired        = 1'b0;
      clicks            = bdcd_pkg::ClickNone;
      click_time        = '0;
      errors            = 0;
    endfunction

    // Keep only the low bits of a register write; drop unmapped indexes
    function void write_reg(logic [bdcd_pkg::CfgIdxW-1:0] idx,
                            logic [bdcd_pkg::MsW-1:0] data);
      case (idx)
        bdcd_pkg::REG_BLOCK_ENABLE:      block_enable      = data[0];
        bdcd_pkg::REG_ACTIVE_LOW:        active_low        = data[0];
        bdcd_pkg::REG_LONG_PRESS_ENABLE: long_press_enable = data[0];
        bdcd_pkg::REG_DEBOUNCE_MS:       debounce_ms       = data;
        bdcd_pkg::REG_LONG_PRESS_MS:     long_press_ms     = data;
        bdcd_pkg::REG_DOUBLE_CLICK_MS:   double_click_ms   = data;
        default: ;
      endcase
    endfunction

    // Advance the tracking state by one accepted poll and queue its events
    function void note_poll(logic level, logic [bdcd_pkg::TimeW-1:0] now_ms);
      bdcd_pkg::res_t ev;
      logic want_pressed;
      ev = '0;
      if (block_enable) begin
        if (level != prev_level) begin
          change_time = now_ms;
        end
        if (bdcd_pkg::TimeW'(now_ms - change_time) > bdcd_pkg::TimeW'(debounce_ms)) begin
          want_pressed = active_low ? ~level : level;
          if (want_pressed && !pressed) begin
            pressed        = 1'b1;
            press_start    = now_ms;
            long_fired     = 1'b0;
            ev.press_event = 1'b1;
          end else if (!want_pressed && pressed) begin
            pressed          = 1'b0;
            ev.release_event = 1'b1;
            // a release after a long press is not a click
            if (!long_fired) begin
              clicks     = clicks + 1'b1;
              click_time = now_ms;
              if (clicks == bdcd_pkg::ClickPair) begin
                ev.double_click_event = 1'b1;
                clicks                = bdcd_pkg::ClickNone;
              end
            end
          end
          if (pressed && !long_fired && long_press_enable &&
              bdcd_pkg::TimeW'(now_ms - press_start) >= bdcd_pkg::TimeW'(long_press_ms)) begin
            long_fired          = 1'b1;
            ev.long_press_event = 1'b1;
          end
        end
        // Close the click window once it has run out
        if (clicks != bdcd_pkg::ClickNone &&
            bdcd_pkg::TimeW'(now_ms - click_time) > bdcd_pkg::TimeW'(double_click_ms)) begin
          if (clicks == bdcd_pkg::ClickSingle) begin
            ev.click_event = 1'b1;
          end
          clicks = bdcd_pkg::ClickNone;
        end
        prev_level = level;
      end
      ev.is_pressed = pressed;
      ev.held_ms    = pressed ? bdcd_pkg::TimeW'(now_ms - press_start) : '0;
      expected_events.push_back(ev);
    endfunction

    function void compare_field(string name, logic [bdcd_pkg::TimeW-1:0] exp_val,
                                logic [bdcd_pkg::TimeW-1:0] act_val);
      if (exp_val !== act_val) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, name, exp_val, act_val);
      end
    endfunction

    // Compare one result transaction with the oldest queued events
    function void check_events(bdcd_pkg::res_t got);
      bdcd_pkg::res_t exp_ev;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual is_pressed %0b held_ms %0d",
                 $time, got.is_pressed, got.held_ms);
      end else begin
        exp_ev = expected_events.pop_front();
        compare_field("press_event", exp_ev.press_event, got.press_event);
        compare_field("release_event", exp_ev.release_event, got.release_event);
        compare_field("long_press_event", exp_ev.long_press_event, got.long_press_event);
        compare_field("click_event", exp_ev.click_event, got.click_event);
        compare_field("double_click_event", exp_ev.double_click_event,
                      got.double_click_event);
        compare_field("is_pressed", exp_ev.is_pressed, got.is_pressed);
        compare_field("held_ms", exp_ev.held_ms, got.held_ms);
      end
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

endpackage

// File: test/tb_button_debounce_click_detector_unit.sv
`timescale 1ns / 1ps
// Testbench top for button_debounce_click_detector_unit: directed polls, then
// phases of bouncy press sequences under varied settings, with random stalls.
// Depends on bdcd_pkg and bdcd_tb_pkg.
module tb_button_debounce_click_detector_unit;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumDirected = 24;
  localparam logic [bdcd_pkg::CfgIdxW-1:0] UnmappedIdxLo =
    bdcd_pkg::CfgIdxW'(bdcd_pkg::REG_DOUBLE_CLICK_MS) + 1'b1;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_raw_level;
  logic [bdcd_pkg::TimeW-1:0]    in_now_ms;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  bdcd_pkg::res_t                out_res;
  logic                          cfg_we;
  logic [bdcd_pkg::CfgIdxW-1:0]  cfg_index;
  logic [bdcd_pkg::MsW-1:0]      cfg_wdata;

  bdcd_tb_pkg::button_event_scoreboard sb;
  logic                          steady_flow;
  logic                          raw_now;
  logic [bdcd_pkg::TimeW-1:0]    time_cursor;
  int unsigned                   polls_sent;
  int unsigned                   stall_cycles = 0;

  // Directed polls under reset settings: clicks, a double click, a long
  // press, a release after it, a lone click timing out and a time wrap
  logic [bdcd_pkg::TimeW-1:0] dir_times [NumDirected] = '{
    32'd0, 32'd10, 32'd61, 32'd100, 32'd151, 32'd200, 32'd251, 32'd260,
    32'd311, 32'd400, 32'd451, 32'd1451, 32'd1500, 32'd1551, 32'd1600, 32'd1651,
    32'd1700, 32'd1751, 32'd2052, 32'hFFFF_FFF0, 32'h0000_0030, 32'h0000_0040,
    32'hFFFF_FFFF, 32'h7FFF_FFFF
  };
  logic dir_levels [NumDirected] = '{
    1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b1
  };

  button_debounce_click_detector_unit u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_raw_level           (in_raw_level),
    .in_now_ms              (in_now_ms),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_press_event        (out_res.press_event),
    .out_release_event      (out_res.release_event),
    .out_long_press_event   (out_res.long_press_event),
    .out_click_event        (out_res.click_event),
    .out_double_click_event (out_res.double_click_event),
    .out_is_pressed         (out_res.is_pressed),
    .out_held_ms            (out_res.held_ms),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Stall the result side at random unless the flow is steady
  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 19);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_events(out_res);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one poll, with an occasional gap, and hold it until accepted
  task automatic send_poll(input logic level, input logic [bdcd_pkg::TimeW-1:0] stamp);
    if (!steady_flow && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_level <= level;
    in_now_ms    <= stamp;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(level, stamp);
    polls_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [bdcd_pkg::CfgIdxW-1:0] idx,
                           input logic [bdcd_pkg::MsW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Write every register, plus one unmapped index that must be ignored
  task automatic load_settings(input logic [bdcd_pkg::MsW-1:0] en, al, lpe, deb, lp, dc);
    cfg_write(bdcd_pkg::REG_BLOCK_ENABLE, en);
    cfg_write(bdcd_pkg::REG_ACTIVE_LOW, al);
    cfg_write(bdcd_pkg::REG_LONG_PRESS_ENABLE, lpe);
    cfg_write(bdcd_pkg::REG_DEBOUNCE_MS, deb);
    cfg_write(bdcd_pkg::REG_LONG_PRESS_MS, lp);
    cfg_write(bdcd_pkg::REG_DOUBLE_CLICK_MS, dc);
    cfg_write(bdcd_pkg::CfgIdxW'($urandom_range(2**bdcd_pkg::CfgIdxW - 1, UnmappedIdxLo)),
              bdcd_pkg::MsW'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
  endtask

  // Mostly bouncy level transitions followed by holds sized to the settings;
  // the rest are time jumps with random levels
  task automatic make_polls(input int unsigned count,
                            input logic [bdcd_pkg::MsW-1:0] deb, lp, dc);
    int unsigned target;
    int unsigned span;
    int unsigned holds;
    int unsigned bounces;
    target = polls_sent + count;
    while (polls_sent < target) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1) == 1) begin
          time_cursor = $urandom();
        end else begin
          time_cursor = bdcd_pkg::TimeW'(32'hFFFF_FFFF - $urandom_range(0, 64));
        end
        raw_now = 1'($urandom_range(0, 1));
        send_poll(raw_now, time_cursor);
      end else begin
        raw_now = ~raw_now;
        bounces = $urandom_range(0, 3);
        repeat (bounces) begin
          time_cursor += $urandom_range(0, int'(deb) / 4 + 1);
          send_poll(1'($urandom_range(0, 1)), time_cursor);
        end
        case ($urandom_range(0, 3))
          0:       span = int'(deb) + 2;
          1:       span = int'(deb) / 2 + 1;
          2:       span = int'(lp) / 3 + 2;
          default: span = int'(dc) / 2 + 2;
        endcase
        holds = $urandom_range(1, 5);
        repeat (holds) begin
          time_cursor += $urandom_range(0, span);
          send_poll(raw_now, time_cursor);
        end
      end
    end
  endtask

  task automatic run_phase(input logic [bdcd_pkg::MsW-1:0] en, al, lpe, deb, lp, dc,
                           input int unsigned count, input logic steady);
    settle();
    load_settings(en, al, lpe, deb, lp, dc);
    steady_flow = steady;
    make_polls(count, deb, lp, dc);
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_raw_level = 1'b1;
    in_now_ms    = '0;
    cfg_we       = 1'b0;
    cfg_index    = bdcd_pkg::REG_BLOCK_ENABLE;
    cfg_wdata    = '0;
    steady_flow  = 1'b0;
    raw_now      = 1'b1;
    time_cursor  = '0;
    polls_sent   = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed polls at reset settings
    for (int i = 0; i < NumDirected; i++) begin
      send_poll(dir_levels[i], dir_times[i]);
    end
    time_cursor = dir_times[NumDirected-1];

    // Random phases: typical, all-zero times, long press off, all-max times,
    // disabled through a wide write, then randomized settings
    run_phase(16'd1, 16'd1, 16'd1, 16'd5, 16'd60, 16'd40, 250, 1'b0);
    run_phase(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 200, 1'b1);
    run_phase(16'd1, 16'd1, 16'd0, 16'd3, 16'd20, 16'd30, 200, 1'b0);
    run_phase(16'd1, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 150, 1'b0);
    run_phase(16'hFFFE, 16'd1, 16'd1, 16'd4, 16'd30, 16'd20, 100, 1'b0);
    run_phase(16'h0003, 16'hFFFF, 16'h0005, bdcd_pkg::MsW'($urandom_range(0, 15)),
              bdcd_pkg::MsW'($urandom_range(0, 100)), bdcd_pkg::MsW'($urandom_range(0, 60)),
              450, 1'b0);

    // Drain and let the pipeline go quiet
    settle();
    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
